FILE: sv/tpsm_pkg.sv
// ----------------------------------------------------------------------------
// tpsm_pkg
// Shared types and constants of the two-point similarity map.
// ----------------------------------------------------------------------------
package tpsm_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam int MUL_CHUNK = 32;

	// The squared scale is 4 * (200/101)^2, kept as an exact ratio.
	localparam int SCALE_NUM_W = 19;
	localparam int SCALE_DEN_W = 15;
	localparam logic signed [SCALE_NUM_W-1:0] SCALE_NUM = 19'sd160000;
	localparam logic signed [SCALE_DEN_W-1:0] SCALE_DEN = 15'sd10201;

	typedef struct packed {
		logic full;
		logic empty;
	} tpsm_qstat_t;

endpackage

FILE: sv/tpsm_fifo.sv
// ----------------------------------------------------------------------------
// tpsm_fifo
// Short queue that decouples the front stage from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module tpsm_fifo #(
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     pop,
	output logic [WIDTH-1:0]         rdata,
	output tpsm_pkg::tpsm_qstat_t    qstat
);
	import tpsm_pkg::*;

	logic [WIDTH-1:0]   mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	assign rdata       = mem_q[rd_q];
	assign qstat.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign qstat.empty = (cnt_q == '0);

endmodule

FILE: sv/tpsm_front.sv
// ----------------------------------------------------------------------------
// tpsm_front
// Accepts items, forms the coordinate differences and flags coincident UV
// references, then hands the item to the queue.
// ----------------------------------------------------------------------------
module tpsm_front #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic signed [W-1:0]   ref1_x,
	input  logic signed [W-1:0]   ref1_y,
	input  logic signed [W-1:0]   ref2_x,
	input  logic signed [W-1:0]   ref2_y,
	input  logic signed [W-1:0]   ref1_u,
	input  logic signed [W-1:0]   ref1_v,
	input  logic signed [W-1:0]   ref2_u,
	input  logic signed [W-1:0]   ref2_v,
	input  logic signed [W-1:0]   target_u,
	input  logic signed [W-1:0]   target_v,
	input  tpsm_pkg::tpsm_qstat_t qstat,
	output logic                  push,
	output logic [8*W+6:0]        wdata
);
	import tpsm_pkg::*;

	logic signed [W:0] dx, dy, du, dv, eu, ev;
	logic              degen;
	logic              v_s1;
	logic [8*W+6:0]    data_s1;

	assign dx    = {ref2_x[W-1], ref2_x} - {ref1_x[W-1], ref1_x};
	assign dy    = {ref2_y[W-1], ref2_y} - {ref1_y[W-1], ref1_y};
	assign du    = {ref2_u[W-1], ref2_u} - {ref1_u[W-1], ref1_u};
	assign dv    = {ref2_v[W-1], ref2_v} - {ref1_v[W-1], ref1_v};
	assign eu    = {target_u[W-1], target_u} - {ref1_u[W-1], ref1_u};
	assign ev    = {target_v[W-1], target_v} - {ref1_v[W-1], ref1_v};
	assign degen = (du == '0) && (dv == '0);

	assign item_ready = !v_s1 || !qstat.full;
	assign push       = v_s1 && !qstat.full;
	assign wdata      = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_ready) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			data_s1 <= {ref1_x, ref1_y, dx, dy, du, dv, eu, ev, degen};
		end
	end

endmodule

FILE: sv/tpsm_dly.sv
// ----------------------------------------------------------------------------
// tpsm_dly
// Stallable delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module tpsm_dly #(
	parameter int DW    = 8,
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] d,
	output logic [DW-1:0] q
);
	logic [DW-1:0] sh_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			sh_q[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				sh_q[k] <= sh_q[k-1];
			end
		end
	end

	assign q = sh_q[DEPTH-1];

endmodule

FILE: sv/tpsm_mul.sv
// ----------------------------------------------------------------------------
// tpsm_mul
// Two-stage signed multiplier: the first operand is cut into chunks whose
// partial products are registered, then summed in the second stage.
// ----------------------------------------------------------------------------
module tpsm_mul #(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	import tpsm_pkg::*;

	localparam int NC  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int EW  = NC * MUL_CHUNK;
	localparam int PPW = MUL_CHUNK + 1 + BW;
	localparam int XW  = EW + BW + 1;

	logic signed [EW-1:0]    a_ext;
	logic signed [PPW-1:0]   pp_s1 [NC];
	logic signed [XW-1:0]    acc;
	logic signed [AW+BW-1:0] p_s2;

	assign a_ext = EW'(a);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NC; i++) begin
				pp_s1[i] <= $signed({(i == NC-1) ? a_ext[i*MUL_CHUNK+MUL_CHUNK-1] : 1'b0,
					a_ext[i*MUL_CHUNK +: MUL_CHUNK]}) * b;
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NC; i++) begin
			acc = acc + (XW'(pp_s1[i]) <<< (i * MUL_CHUNK));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= acc[AW+BW-1:0];
		end
	end

	assign p = p_s2;

endmodule

FILE: sv/tpsm_div.sv
// ----------------------------------------------------------------------------
// tpsm_div
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// limited to QW bits; a larger quotient raises ovf.
// ----------------------------------------------------------------------------
module tpsm_div #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);
	localparam int HW = NW - QW;
	localparam int KW = (HW > DW) ? HW : DW;

	logic [DW-1:0] rem_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] lo_q  [QW];
	logic [QW-1:0] quo_q [QW+1];
	logic          ovf_q [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= DW'(num[NW-1:QW]);
			den_q[0] <= den;
			lo_q[0]  <= num[QW-1:0];
			quo_q[0] <= '0;
			ovf_q[0] <= (KW'(num[NW-1:QW]) >= KW'(den));
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [DW:0] t;
		logic        take;

		assign t    = {rem_q[i], lo_q[i][QW-1]};
		assign take = (t >= {1'b0, den_q[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[i+1] <= {quo_q[i][QW-2:0], take};
				ovf_q[i+1] <= ovf_q[i];
			end
		end

		if (i < QW-1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[i+1] <= take ? DW'(t - {1'b0, den_q[i]}) : DW'(t);
					den_q[i+1] <= den_q[i];
					lo_q[i+1]  <= lo_q[i] << 1;
				end
			end
		end
	end

	assign quo = quo_q[QW];
	assign ovf = ovf_q[QW];

endmodule

FILE: sv/tpsm_sqrt.sv
// ----------------------------------------------------------------------------
// tpsm_sqrt
// Pipelined integer square root, one root bit per stage. A set ovf_in
// forces the root to all ones.
// ----------------------------------------------------------------------------
module tpsm_sqrt #(
	parameter int RW = 34
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] x,
	input  logic            ovf_in,
	output logic [RW-1:0]   root
);
	logic [RW+1:0]   rem_q  [RW];
	logic [RW-1:0]   root_q [RW];
	logic [2*RW-1:0] xr_q   [RW];
	logic            ovf_q  [RW];

	for (genvar j = 0; j < RW; j++) begin : g_step
		logic [RW+1:0]   rem_c;
		logic [RW-1:0]   root_c;
		logic [2*RW-1:0] xr_c;
		logic            ovf_c;
		logic [RW+3:0]   t;
		logic [RW+3:0]   trial;
		logic            take;

		if (j == 0) begin : g_first
			assign rem_c  = '0;
			assign root_c = '0;
			assign xr_c   = x;
			assign ovf_c  = ovf_in;
		end else begin : g_next
			assign rem_c  = rem_q[j-1];
			assign root_c = root_q[j-1];
			assign xr_c   = xr_q[j-1];
			assign ovf_c  = ovf_q[j-1];
		end

		assign t     = {rem_c, xr_c[2*RW-1:2*RW-2]};
		assign trial = {(RW+2)'(root_c), 2'b01};
		assign take  = (t >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_q[j] <= {root_c[RW-2:0], take};
				ovf_q[j]  <= ovf_c;
			end
		end

		if (j < RW-1) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_q[j] <= take ? (RW+2)'(t - trial) : (RW+2)'(t);
					xr_q[j]  <= xr_c << 2;
				end
			end
		end
	end

	assign root = ovf_q[RW-1] ? '1 : root_q[RW-1];

endmodule

FILE: sv/tpsm_back.sv
// ----------------------------------------------------------------------------
// tpsm_back
// Arithmetic pipeline: complex products, rounded divisions, scale square
// root and output saturation. The whole pipeline stalls on the output.
// ----------------------------------------------------------------------------
module tpsm_back #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [8*W+6:0]        qdata,
	input  tpsm_pkg::tpsm_qstat_t qstat,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic signed [W-1:0]   mapped_x,
	output logic signed [W-1:0]   mapped_y,
	output logic [W-1:0]          scale_ratio,
	output logic                  degenerate
);
	import tpsm_pkg::*;

	localparam int L    = 3*W + 14;
	localparam int PW1  = 2*W + 2;
	localparam int ARW  = 2*W + 3;
	localparam int DENW = 2*W + 1;
	localparam int PW2  = 3*W + 4;
	localparam int NRW  = 3*W + 5;
	localparam int NXW  = 3*W + 6;
	localparam int KPW  = 2*W + 19;
	localparam int DDW  = 2*W + 15;
	localparam int QXW  = W + 1;
	localparam int QSW  = 2*W + 4;
	localparam int RTW  = W + 2;

	logic              en;
	logic [L-1:0]      vld_q;

	logic signed [W-1:0] p1x, p1y;
	logic signed [W:0]   dx, dy, du, dv, eu, ev;
	logic                degen;

	logic signed [PW1-1:0] m_eudx, m_evdy, m_eudy, m_evdx;
	logic signed [PW1-1:0] m_dudu, m_dvdv, m_dxdx, m_dydy;
	logic [2*W+1:0]        duv_d;
	logic signed [W:0]     du_d, dv_d;

	logic signed [ARW-1:0] ar_s3, ai_s3;
	logic [DENW-1:0]       den_s3, pp_s3, den_d;

	logic signed [PW2-1:0]             m_ardu, m_aidv, m_aidu, m_ardv;
	logic signed [2*W+SCALE_NUM_W+1:0] m_ppk;
	logic signed [2*W+SCALE_DEN_W+1:0] m_ddk;

	logic signed [NRW-1:0] nr, ni;
	logic [NRW-1:0]        anr, ani;
	logic [NXW-1:0]        numx_s6, numy_s6;
	logic [DENW:0]         dv_s6;
	logic                  sx_s6, sy_s6;
	logic [KPW-1:0]        nums_s6;
	logic [DDW-1:0]        dds_s6;

	logic [QXW-1:0] quo_x, quo_y;
	logic           ovf_x, ovf_y;
	logic [QSW-1:0] quo_s;
	logic           ovf_s;
	logic [RTW-1:0] root;

	logic [QXW-1:0]      qx_d, qy_d;
	logic                ovx_d, ovy_d, sx_d, sy_d, degen_d;
	logic signed [W-1:0] p1x_d, p1y_d;

	logic [W+1:0]        qex, qey;
	logic signed [W+2:0] qsx, qsy, vx, vy;
	logic [W+2:0]        rs1;
	logic [W+1:0]        rsc;
	logic signed [W-1:0] satx, saty;
	logic [W-1:0]        sats;

	logic signed [W-1:0] mapped_x_q, mapped_y_q;
	logic [W-1:0]        scale_q;
	logic                degen_q;

	assign en           = !result_valid || result_ready;
	assign pop          = en && !qstat.empty;
	assign result_valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], !qstat.empty};
		end
	end

	assign {p1x, p1y, dx, dy, du, dv, eu, ev, degen} = qdata;

	tpsm_mul #(.AW(W+1), .BW(W+1)) u_m0 (.clk, .en, .a(eu), .b(dx), .p(m_eudx));
	tpsm_mul #(.AW(W+1), .BW(W+1)) u_m1 (.clk, .en, .a(ev), .b(dy), .p(m_evdy));
	tpsm_mul #(.AW(W+1), .BW(W+1)) u_m2 (.clk, .en, .a(eu), .b(dy), .p(m_eudy));
	tpsm_mul #(.AW(W+1), .BW(W+1)) u_m3 (.clk, .en, .a(ev), .b(dx), .p(m_evdx));
	tpsm_mul #(.AW(W+1), .BW(W+1)) u_m4 (.clk, .en, .a(du), .b(du), .p(m_dudu));
	tpsm_mul #(.AW(W+1), .BW(W+1)) u_m5 (.clk, .en, .a(dv), .b(dv), .p(m_dvdv));
	tpsm_mul #(.AW(W+1), .BW(W+1)) u_m6 (.clk, .en, .a(dx), .b(dx), .p(m_dxdx));
	tpsm_mul #(.AW(W+1), .BW(W+1)) u_m7 (.clk, .en, .a(dy), .b(dy), .p(m_dydy));

	tpsm_dly #(.DW(2*W+2), .DEPTH(3)) u_dly_duv (
		.clk, .en, .d({du, dv}), .q(duv_d)
	);
	assign {du_d, dv_d} = duv_d;

	always_ff @(posedge clk) begin
		if (en) begin
			ar_s3  <= ARW'(m_eudx) - ARW'(m_evdy);
			ai_s3  <= ARW'(m_eudy) + ARW'(m_evdx);
			den_s3 <= DENW'(m_dudu) + DENW'(m_dvdv);
			pp_s3  <= DENW'(m_dxdx) + DENW'(m_dydy);
		end
	end

	tpsm_mul #(.AW(ARW), .BW(W+1)) u_m8  (.clk, .en, .a(ar_s3), .b(du_d), .p(m_ardu));
	tpsm_mul #(.AW(ARW), .BW(W+1)) u_m9  (.clk, .en, .a(ai_s3), .b(dv_d), .p(m_aidv));
	tpsm_mul #(.AW(ARW), .BW(W+1)) u_m10 (.clk, .en, .a(ai_s3), .b(du_d), .p(m_aidu));
	tpsm_mul #(.AW(ARW), .BW(W+1)) u_m11 (.clk, .en, .a(ar_s3), .b(dv_d), .p(m_ardv));
	tpsm_mul #(.AW(DENW+1), .BW(SCALE_NUM_W)) u_m12 (
		.clk, .en, .a($signed({1'b0, pp_s3})), .b(SCALE_NUM), .p(m_ppk)
	);
	tpsm_mul #(.AW(DENW+1), .BW(SCALE_DEN_W)) u_m13 (
		.clk, .en, .a($signed({1'b0, den_s3})), .b(SCALE_DEN), .p(m_ddk)
	);

	tpsm_dly #(.DW(DENW), .DEPTH(2)) u_dly_den (
		.clk, .en, .d(den_s3), .q(den_d)
	);

	assign nr  = NRW'(m_ardu) + NRW'(m_aidv);
	assign ni  = NRW'(m_aidu) - NRW'(m_ardv);
	assign anr = nr[NRW-1] ? NRW'(-nr) : NRW'(nr);
	assign ani = ni[NRW-1] ? NRW'(-ni) : NRW'(ni);

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s6 <= {anr, 1'b0} + NXW'(den_d);
			numy_s6 <= {ani, 1'b0} + NXW'(den_d);
			dv_s6   <= {den_d, 1'b0};
			sx_s6   <= nr[NRW-1];
			sy_s6   <= ni[NRW-1];
			nums_s6 <= m_ppk[KPW-1:0];
			dds_s6  <= m_ddk[DDW-1:0];
		end
	end

	tpsm_div #(.NW(NXW), .DW(DENW+1), .QW(QXW)) u_div_x (
		.clk, .en, .num(numx_s6), .den(dv_s6), .quo(quo_x), .ovf(ovf_x)
	);
	tpsm_div #(.NW(NXW), .DW(DENW+1), .QW(QXW)) u_div_y (
		.clk, .en, .num(numy_s6), .den(dv_s6), .quo(quo_y), .ovf(ovf_y)
	);
	tpsm_div #(.NW(KPW+2*F), .DW(DDW), .QW(QSW)) u_div_s (
		.clk, .en, .num({nums_s6, {(2*F){1'b0}}}), .den(dds_s6), .quo(quo_s), .ovf(ovf_s)
	);
	tpsm_sqrt #(.RW(RTW)) u_sqrt (
		.clk, .en, .x(quo_s), .ovf_in(ovf_s), .root(root)
	);

	tpsm_dly #(.DW(2*QXW+2), .DEPTH(2*W+5)) u_dly_q (
		.clk, .en, .d({quo_x, ovf_x, quo_y, ovf_y}), .q({qx_d, ovx_d, qy_d, ovy_d})
	);
	tpsm_dly #(.DW(2), .DEPTH(3*W+7)) u_dly_sgn (
		.clk, .en, .d({sx_s6, sy_s6}), .q({sx_d, sy_d})
	);
	tpsm_dly #(.DW(2*W+1), .DEPTH(3*W+13)) u_dly_p1 (
		.clk, .en, .d({p1x, p1y, degen}), .q({p1x_d, p1y_d, degen_d})
	);

	always_comb begin
		qex  = ovx_d ? {1'b1, {(W+1){1'b0}}} : {1'b0, qx_d};
		qey  = ovy_d ? {1'b1, {(W+1){1'b0}}} : {1'b0, qy_d};
		qsx  = sx_d ? -$signed({1'b0, qex}) : $signed({1'b0, qex});
		qsy  = sy_d ? -$signed({1'b0, qey}) : $signed({1'b0, qey});
		vx   = (W+3)'(p1x_d) + qsx;
		vy   = (W+3)'(p1y_d) + qsy;
		satx = vx[W-1:0];
		if (!((vx[W+2:W-1] == '0) || (vx[W+2:W-1] == '1))) begin
			satx = vx[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		saty = vy[W-1:0];
		if (!((vy[W+2:W-1] == '0) || (vy[W+2:W-1] == '1))) begin
			saty = vy[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end
		rs1  = {1'b0, root} + (W+3)'(1);
		rsc  = rs1[W+2:1];
		sats = (rsc[W+1:W] != '0) ? '1 : rsc[W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mapped_x_q <= degen_d ? '0 : satx;
			mapped_y_q <= degen_d ? '0 : saty;
			scale_q    <= degen_d ? '0 : sats;
			degen_q    <= degen_d;
		end
	end

	assign mapped_x    = mapped_x_q;
	assign mapped_y    = mapped_y_q;
	assign scale_ratio = scale_q;
	assign degenerate  = degen_q;

`ifndef ASSERT_OFF
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |-> mapped_x == '0 && mapped_y == '0 && scale_ratio == '0)
		else $error("degenerate result carries nonzero values");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while the output was stalled");

	a_pop_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> vld_q[0])
		else $error("item taken from the queue was not entered into the pipeline");
`endif

endmodule

FILE: sv/two_point_similarity_map.sv
// ----------------------------------------------------------------------------
// two_point_similarity_map
// Maps a UV target into XY with the similarity transform fixed by two
// reference point pairs, and reports the XY over UV scale divided by 0.505.
// ----------------------------------------------------------------------------
// Usage: present an item on the input channel with item_valid; it is taken
// when item_ready is also high. Results leave on the result channel, one per
// item and in order, and are taken when result_valid and result_ready are
// both high. Coordinates are signed fixed point with FRAC_BITS fraction bits.
// The divider and square root pipelines resolve one bit per stage. Throughput
// is one item per cycle while the receiver takes results. The input register
// feeds a four-entry queue, so the input keeps accepting while the back
// pipeline is stalled until the queue fills; a stalled receiver freezes the
// back pipeline and holds the result. Reset empties the queue and the
// pipeline; no result is pending after it.
// Coincident UV references give degenerate = 1 with zero values.
// ----------------------------------------------------------------------------
module two_point_similarity_map #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [COORD_WIDTH-1:0] ref1_x,
	input  logic signed [COORD_WIDTH-1:0] ref1_y,
	input  logic signed [COORD_WIDTH-1:0] ref2_x,
	input  logic signed [COORD_WIDTH-1:0] ref2_y,
	input  logic signed [COORD_WIDTH-1:0] ref1_u,
	input  logic signed [COORD_WIDTH-1:0] ref1_v,
	input  logic signed [COORD_WIDTH-1:0] ref2_u,
	input  logic signed [COORD_WIDTH-1:0] ref2_v,
	input  logic signed [COORD_WIDTH-1:0] target_u,
	input  logic signed [COORD_WIDTH-1:0] target_v,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [COORD_WIDTH-1:0] mapped_x,
	output logic signed [COORD_WIDTH-1:0] mapped_y,
	output logic [COORD_WIDTH-1:0]        scale_ratio,
	output logic                          degenerate
);
	import tpsm_pkg::*;

	localparam int IW = 8*COORD_WIDTH + 7;

	logic           push;
	logic           pop;
	logic [IW-1:0]  wdata;
	logic [IW-1:0]  rdata;
	tpsm_qstat_t    qstat;

	tpsm_front #(.W(COORD_WIDTH)) u_front (
		.clk, .arst_n, .item_valid, .item_ready,
		.ref1_x, .ref1_y, .ref2_x, .ref2_y,
		.ref1_u, .ref1_v, .ref2_u, .ref2_v,
		.target_u, .target_v,
		.qstat, .push, .wdata
	);

	tpsm_fifo #(.WIDTH(IW)) u_fifo (
		.clk, .arst_n, .push, .wdata, .pop, .rdata, .qstat
	);

	tpsm_back #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_back (
		.clk, .arst_n, .qdata(rdata), .qstat, .pop,
		.result_valid, .result_ready,
		.mapped_x, .mapped_y, .scale_ratio, .degenerate
	);

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-point similarity map testbench
// Sends directed and random reference pairs and targets through the map and
// compares every result with a given value or a wide-integer model of the
// transform. The input idles and the output stalls at random, over several phases.
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic signed [31:0] p1x, p1y, p2x, p2y, q1u, q1v, q2u, q2v, tu, tv;
	} pose_in_t;

	typedef struct packed {
		logic signed [31:0] mx, my;
		logic [31:0]        sc;
		logic               deg;
	} map_res_t;

	typedef struct {
		pose_in_t pose;
		bit       typed;
		map_res_t res;
	} dir_row_t;

	localparam logic signed [31:0] CMAX = 32'sh7fffffff;
	localparam logic signed [31:0] CMIN = 32'sh80000000;
	localparam logic signed [255:0] SMAX = 256'sd2147483647;
	localparam logic signed [255:0] SMIN = -SMAX - 1;

	logic clk, arst_n;
	logic item_valid, item_ready, result_valid, result_ready;
	logic signed [31:0] ref1_x, ref1_y, ref2_x, ref2_y, ref1_u, ref1_v;
	logic signed [31:0] ref2_u, ref2_v, target_u, target_v;
	logic signed [31:0] mapped_x, mapped_y;
	logic [31:0] scale_ratio;
	logic degenerate;

	map_res_t expected_maps[$];
	dir_row_t dir_rows[$];
	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	two_point_similarity_map dut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic signed [255:0] round_div(logic signed [255:0] n, logic [255:0] d);
		logic [255:0] mag, q;
		mag = (n < 0) ? -n : n;
		q = (2 * mag + d) / (2 * d);
		return (n < 0) ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [31:0] sat_coord(logic signed [255:0] v);
		if (v > SMAX)
			return CMAX;
		if (v < SMIN)
			return CMIN;
		return v[31:0];
	endfunction

	function automatic map_res_t predict_map(pose_in_t a);
		logic signed [255:0] dx, dy, du, dv, eu, ev, ar, ai, nr, ni;
		logic [255:0] den, pp, num, dd, x4, s, c, r;
		map_res_t o;
		o = '0;
		dx = a.p2x - a.p1x;
		dy = a.p2y - a.p1y;
		du = a.q2u - a.q1u;
		dv = a.q2v - a.q1v;
		eu = a.tu - a.q1u;
		ev = a.tv - a.q1v;
		den = du * du + dv * dv;
		if (den == 0) begin
			o.deg = 1'b1;
			return o;
		end
		ar = eu * dx - ev * dy;
		ai = eu * dy + ev * dx;
		nr = ar * du + ai * dv;
		ni = ai * du - ar * dv;
		o.mx = sat_coord(a.p1x + round_div(nr, $signed(den)));
		o.my = sat_coord(a.p1y + round_div(ni, $signed(den)));
		pp = dx * dx + dy * dy;
		num = (pp * 256'd160000) << 32;
		dd = den * 256'd10201;
		x4 = num / dd;
		s = '0;
		for (int b = 33; b >= 0; b--) begin
			c = s + (256'd1 << b);
			if (c * c <= x4)
				s = c;
		end
		r = (s + 1) >> 1;
		o.sc = (r > 256'hffffffff) ? 32'hffffffff : r[31:0];
		return o;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		logic signed [31:0] v;
		case ($urandom_range(7))
			0, 1: v = $urandom;
			2: v = ($signed($urandom_range(20)) - 10) * 65536 + $signed($urandom_range(65535));
			3: case ($urandom_range(4))
				0: v = CMAX;
				1: v = CMIN;
				2: v = 0;
				3: v = -1;
				default: v = 1;
			endcase
			default: v = $signed($urandom) >>> $urandom_range(4, 16);
		endcase
		return v;
	endfunction

	function automatic pose_in_t rand_pose();
		pose_in_t a;
		a = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
		case ($urandom_range(19))
			0, 1: begin
				a.q2u = a.q1u;
				a.q2v = a.q1v;
			end
			2, 3: begin
				a.p2x = a.p1x;
				a.p2y = a.p1y;
			end
			4, 5: begin
				a.tu = a.q1u;
				a.tv = a.q1v;
			end
			6: begin
				a.q2u = a.q1u + 1;
				a.q2v = a.q1v;
			end
			default: ;
		endcase
		return a;
	endfunction

	task automatic send_pose(pose_in_t a, bit typed, map_res_t e);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		{ref1_x, ref1_y, ref2_x, ref2_y, ref1_u, ref1_v, ref2_u, ref2_v, target_u, target_v} <= a;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		expected_maps.push_back(typed ? e : predict_map(a));
	endtask

	task automatic add_row(pose_in_t a, bit typed, map_res_t e);
		dir_row_t row;
		row.pose = a;
		row.typed = typed;
		row.res = e;
		dir_rows.push_back(row);
	endtask

	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		map_res_t e;
		if (arst_n && result_valid && result_ready) begin
			if (expected_maps.size() == 0) begin
				$error("result with no item pending");
				errors++;
			end else begin
				e = expected_maps.pop_front();
				if (mapped_x !== e.mx) begin
					$error("mapped_x expected %0d got %0d", e.mx, mapped_x);
					errors++;
				end
				if (mapped_y !== e.my) begin
					$error("mapped_y expected %0d got %0d", e.my, mapped_y);
					errors++;
				end
				if (scale_ratio !== e.sc) begin
					$error("scale_ratio expected %0d got %0d", e.sc, scale_ratio);
					errors++;
				end
				if (degenerate !== e.deg) begin
					$error("degenerate expected %0d got %0d", e.deg, degenerate);
					errors++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		{ref1_x, ref1_y, ref2_x, ref2_y, ref1_u, ref1_v, ref2_u, ref2_v, target_u, target_v} = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		add_row('0, 1, '{0, 0, 0, 1});
		add_row({CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN}, 1, '{0, 0, 0, 1});
		add_row({CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX}, 1, '{0, 0, 0, 1});
		add_row({32'sd12345, -32'sd777, 32'sd12345, -32'sd777, 32'sd0, 32'sd0,
			32'sd65536, 32'sd0, CMAX, CMIN}, 1, '{12345, -777, 0, 0});
		add_row({CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX},
			1, '{CMIN, CMIN, 0, 0});
		add_row({32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0,
			32'sd327680, 32'sd196608}, 0, '0);
		add_row({32'sd100, 32'sd200, 32'sd9000, -32'sd4000, 32'sd5, 32'sd6, 32'sd70000,
			-32'sd3, 32'sd5, 32'sd6}, 0, '0);
		add_row({CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN}, 0, '0);
		add_row({CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX}, 0, '0);
		add_row({CMIN, CMAX, CMAX, CMIN, 32'sd0, 32'sd0, 32'sd1, 32'sd0, CMAX, CMAX}, 0, '0);
		add_row({CMAX, CMIN, CMIN, CMAX, 32'sd0, 32'sd0, 32'sd0, 32'sd1, CMIN, CMAX}, 0, '0);
		add_row({32'sd0, 32'sd0, CMAX, CMAX, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd0, 32'sd0},
			0, '0);
		add_row({-32'sd1, -32'sd1, -32'sd1, -32'sd2, -32'sd1, -32'sd1, -32'sd2, -32'sd1,
			-32'sd1, -32'sd2}, 0, '0);
		add_row({32'sd1, 32'sd1, 32'sd3, 32'sd1, 32'sd0, 32'sd0, 32'sd2, 32'sd0,
			32'sd1, 32'sd0}, 0, '0);

		foreach (dir_rows[i])
			send_pose(dir_rows[i].pose, dir_rows[i].typed, dir_rows[i].res);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 67 : (ph == 3) ? 38 : 0;
			stall_pct = (ph == 2) ? 67 : (ph == 3) ? 38 : 0;
			repeat (500)
				send_pose(rand_pose(), 0, '0);
		end
		item_valid <= 1'b0;
		stall_pct = 0;

		while (expected_maps.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
sv/tpsm_pkg.sv
sv/tpsm_fifo.sv
sv/tpsm_front.sv
sv/tpsm_dly.sv
sv/tpsm_mul.sv
sv/tpsm_div.sv
sv/tpsm_sqrt.sv
sv/tpsm_back.sv
sv/two_point_similarity_map.sv
tb/sv/tb.sv
